// ===== src/taq_pkg.sv =====
// Shared widths, constants and control types for the two-axis to quaternion block.
// No dependencies.
package taq_pkg;

    localparam int IN_W      = 16;
    localparam int OUT_W     = 16;
    localparam int UNIT_W    = 32;
    localparam int MAG_MSB   = 29;
    localparam int FRAC      = 30;
    localparam int CX_SHIFT  = 17;
    localparam int Q_W       = 36;
    localparam int N_AX      = 3;
    localparam int N_Q       = 4;
    localparam int C1_W      = 2 * IN_W + 1;
    localparam int C2_W      = UNIT_W + IN_W + 1;
    localparam int XS_W      = N_AX * IN_W;
    localparam int ZS_W      = N_AX * UNIT_W;

    localparam logic signed [Q_W-1:0]   ONE_Q30  = 36'sh0_4000_0000;
    localparam logic signed [OUT_W-1:0] Q14_ONE  = 16'sd16384;
    localparam logic [UNIT_W-1:0]       RND_HALF = 32'h0000_8000;

    typedef struct packed {
        logic valid;
        logic zero;
    } t_uctl;

endpackage

// ===== src/taq_cross.sv =====
// Two-stage pipelined 3-vector cross product with a sideband carried alongside.
// Depends on taq_pkg.
module taq_cross #(
    parameter int AW = 16,
    parameter int BW = 16,
    parameter int SW = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [AW-1:0] i_a [taq_pkg::N_AX],
    input  logic signed [BW-1:0] i_b [taq_pkg::N_AX],
    input  logic [SW-1:0]        i_side,
    output logic                 o_valid,
    output logic signed [AW+BW:0] o_c [taq_pkg::N_AX],
    output logic [SW-1:0]        o_side
);
    import taq_pkg::*;

    localparam int PW = AW + BW;
    localparam int CW = AW + BW + 1;

    logic signed [PW-1:0] r_p [6];
    logic [SW-1:0]        r_side;
    logic                 r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v     <= i_valid;
            o_valid <= r_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p[0] <= i_a[1] * i_b[2];
        r_p[1] <= i_a[2] * i_b[1];
        r_p[2] <= i_a[2] * i_b[0];
        r_p[3] <= i_a[0] * i_b[2];
        r_p[4] <= i_a[0] * i_b[1];
        r_p[5] <= i_a[1] * i_b[0];
        r_side <= i_side;
        o_c[0] <= CW'(r_p[0]) - CW'(r_p[1]);
        o_c[1] <= CW'(r_p[2]) - CW'(r_p[3]);
        o_c[2] <= CW'(r_p[4]) - CW'(r_p[5]);
        o_side <= r_side;
    end

endmodule

// ===== src/taq_unitize.sv =====
// Pipelined vector normalization to Q30: magnitude, block shift, sum of squares,
// one root bit per stage, one quotient bit per stage. Depends on taq_pkg.
module taq_unitize #(
    parameter int N  = 3,
    parameter int WI = 33,
    parameter int SW = 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic signed [WI-1:0]            i_v [N],
    input  logic [SW-1:0]                   i_side,
    output taq_pkg::t_uctl                  o_ctl,
    output logic signed [taq_pkg::UNIT_W-1:0] o_u [N],
    output logic [SW-1:0]                   o_side
);
    import taq_pkg::*;

    localparam int MW   = WI;
    localparam int PW   = $clog2(MW);
    localparam int SQW  = 2 * (MAG_MSB + 1);
    localparam int SUMW = SQW + 2;
    localparam int TW   = SUMW + 1;
    localparam int RW   = MAG_MSB + 2;
    localparam int SQ_N = RW;
    localparam int NW   = SUMW;
    localparam int DV_N = FRAC + 1;
    localparam int MS   = MAG_MSB + 1;

    function automatic logic [PW-1:0] lead(input logic [MW-1:0] v);
        logic [PW-1:0] p;
        p = '0;
        for (int b = 0; b < MW; b++) begin
            if (v[b]) p = PW'(b);
        end
        return p;
    endfunction

    // front stages
    logic            r_v1, r_v2, r_v3, r_v4;
    logic [MW-1:0]   r_m1 [N];
    logic [MW-1:0]   r_m2 [N];
    logic [N-1:0]    r_n1, r_n2, r_n3, r_n4;
    logic [MW-1:0]   r_or1;
    logic [PW-1:0]   r_p2;
    logic            r_z2, r_z3, r_z4;
    logic [MS-1:0]   r_m3 [N];
    logic [MS-1:0]   r_m4 [N];
    logic [SQW-1:0]  r_sq4 [N];
    logic [SW-1:0]   r_s1, r_s2, r_s3, r_s4;

    // root stages
    logic            r_qv [SQ_N+1];
    logic            r_qz [SQ_N+1];
    logic [N-1:0]    r_qn [SQ_N+1];
    logic [MS-1:0]   r_qm [SQ_N+1][N];
    logic [SUMW-1:0] r_rem [SQ_N+1];
    logic [RW-1:0]   r_root [SQ_N+1];
    logic [SW-1:0]   r_qs [SQ_N+1];

    // divide stages
    logic            r_dv [DV_N+1];
    logic            r_dz [DV_N+1];
    logic [N-1:0]    r_dn [DV_N+1];
    logic [RW-1:0]   r_dr [DV_N+1];
    logic [NW-1:0]   r_num [DV_N+1][N];
    logic [DV_N-1:0] r_q [DV_N+1][N];
    logic [SW-1:0]   r_ds [DV_N+1];

    logic [MW-1:0]   n_or;
    logic [MS-1:0]   n_m3 [N];
    logic [SUMW-1:0] n_sum;

    always_comb begin
        n_or = '0;
        for (int j = 0; j < N; j++) begin
            n_or = n_or | (i_v[j][WI-1] ? MW'(-i_v[j]) : MW'(i_v[j]));
        end
    end

    always_comb begin
        logic [MW+MS-1:0] ext;
        for (int j = 0; j < N; j++) begin
            ext = {{MS{1'b0}}, r_m2[j]};
            if (r_p2 >= PW'(MAG_MSB)) ext = ext >> (r_p2 - PW'(MAG_MSB));
            else                      ext = ext << (PW'(MAG_MSB) - r_p2);
            n_m3[j] = ext[MS-1:0];
        end
    end

    always_comb begin
        n_sum = '0;
        for (int j = 0; j < N; j++) n_sum = n_sum + SUMW'(r_sq4[j]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            r_qv[0] <= 1'b0;
        end else begin
            r_v1    <= i_valid;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            r_qv[0] <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < N; j++) begin
            r_n1[j]  <= i_v[j][WI-1];
            r_m1[j]  <= i_v[j][WI-1] ? MW'(-i_v[j]) : MW'(i_v[j]);
            r_m2[j]  <= r_m1[j];
            r_m3[j]  <= n_m3[j];
            r_m4[j]  <= r_m3[j];
            r_sq4[j] <= SQW'(r_m3[j]) * SQW'(r_m3[j]);
            r_qm[0][j] <= r_m4[j];
        end
        r_or1     <= n_or;
        r_s1      <= i_side;
        r_p2      <= lead(r_or1);
        r_z2      <= (r_or1 == '0);
        r_n2      <= r_n1;
        r_s2      <= r_s1;
        r_z3      <= r_z2;
        r_n3      <= r_n2;
        r_s3      <= r_s2;
        r_z4      <= r_z3;
        r_n4      <= r_n3;
        r_s4      <= r_s3;
        r_qz[0]   <= r_z4;
        r_qn[0]   <= r_n4;
        r_qs[0]   <= r_s4;
        r_rem[0]  <= n_sum;
        r_root[0] <= '0;
    end

    for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
        localparam int BI = SQ_N - 1 - k;
        logic [TW-1:0] term;
        assign term = (TW'(r_root[k]) << (BI + 1)) + (TW'(1) << (2 * BI));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_qv[k+1] <= 1'b0;
            else          r_qv[k+1] <= r_qv[k];
        end

        always_ff @(posedge i_clk) begin
            if ({1'b0, r_rem[k]} >= term) begin
                r_rem[k+1]  <= SUMW'({1'b0, r_rem[k]} - term);
                r_root[k+1] <= r_root[k] | (RW'(1) << BI);
            end else begin
                r_rem[k+1]  <= r_rem[k];
                r_root[k+1] <= r_root[k];
            end
            r_qz[k+1] <= r_qz[k];
            r_qn[k+1] <= r_qn[k];
            r_qs[k+1] <= r_qs[k];
            for (int j = 0; j < N; j++) r_qm[k+1][j] <= r_qm[k][j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dv[0] <= 1'b0;
        else          r_dv[0] <= r_qv[SQ_N];
    end

    always_ff @(posedge i_clk) begin
        r_dz[0] <= r_qz[SQ_N];
        r_dn[0] <= r_qn[SQ_N];
        r_ds[0] <= r_qs[SQ_N];
        r_dr[0] <= r_root[SQ_N];
        for (int j = 0; j < N; j++) begin
            r_num[0][j] <= (NW'(r_qm[SQ_N][j]) << FRAC) + NW'(r_root[SQ_N] >> 1);
            r_q[0][j]   <= '0;
        end
    end

    for (genvar k = 0; k < DV_N; k++) begin : g_div
        localparam int BI = DV_N - 1 - k;
        logic [NW-1:0] dv;
        assign dv = NW'(r_dr[k]) << BI;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_dv[k+1] <= 1'b0;
            else          r_dv[k+1] <= r_dv[k];
        end

        always_ff @(posedge i_clk) begin
            for (int j = 0; j < N; j++) begin
                if (r_num[k][j] >= dv) begin
                    r_num[k+1][j] <= r_num[k][j] - dv;
                    r_q[k+1][j]   <= r_q[k][j] | (DV_N'(1) << BI);
                end else begin
                    r_num[k+1][j] <= r_num[k][j];
                    r_q[k+1][j]   <= r_q[k][j];
                end
            end
            r_dz[k+1] <= r_dz[k];
            r_dn[k+1] <= r_dn[k];
            r_dr[k+1] <= r_dr[k];
            r_ds[k+1] <= r_ds[k];
        end
    end

    always_ff @(posedge i_clk) begin
        logic [UNIT_W-1:0] qe;
        if (!i_rst_n) o_ctl.valid <= 1'b0;
        else          o_ctl.valid <= r_dv[DV_N];
        for (int j = 0; j < N; j++) begin
            qe = UNIT_W'(r_q[DV_N][j]);
            o_u[j] <= r_dn[DV_N][j] ? -qe : qe;
        end
        o_ctl.zero <= r_dz[DV_N];
        o_side     <= r_ds[DV_N];
    end

endmodule

// ===== src/two_axis_to_quaternion.sv =====
// Throughput: one item per cycle.
// Depth: three normalizers of 69 stages each (front, one root bit and one quotient bit
// per stage), two stages per cross product, two trace stages and the output register.
// busy never rises; the receiver cannot stall, so o_done pulses once per item.
// Reset (i_rst_n low, synchronous) clears every valid bit; data registers hold garbage.
// Depends on taq_pkg, taq_cross, taq_unitize.
module two_axis_to_quaternion (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [taq_pkg::IN_W-1:0]  i_xaxis_x,
    input  logic signed [taq_pkg::IN_W-1:0]  i_xaxis_y,
    input  logic signed [taq_pkg::IN_W-1:0]  i_xaxis_z,
    input  logic signed [taq_pkg::IN_W-1:0]  i_yaxis_x,
    input  logic signed [taq_pkg::IN_W-1:0]  i_yaxis_y,
    input  logic signed [taq_pkg::IN_W-1:0]  i_yaxis_z,
    output logic                             o_done,
    output logic signed [taq_pkg::OUT_W-1:0] o_quat_w,
    output logic signed [taq_pkg::OUT_W-1:0] o_quat_x,
    output logic signed [taq_pkg::OUT_W-1:0] o_quat_y,
    output logic signed [taq_pkg::OUT_W-1:0] o_quat_z,
    output logic                             o_degenerate
);
    import taq_pkg::*;

    localparam int S2_W = 1 + ZS_W + XS_W;

    logic signed [IN_W-1:0]   xr [N_AX];
    logic signed [IN_W-1:0]   yr [N_AX];
    logic                     c1_v;
    logic signed [C1_W-1:0]   c1 [N_AX];
    logic [XS_W-1:0]          c1_s;
    t_uctl                    u1_ctl;
    logic signed [UNIT_W-1:0] u1 [N_AX];
    logic [XS_W-1:0]          u1_s;
    logic signed [IN_W-1:0]   u1_x [N_AX];
    logic                     c2_v;
    logic signed [C2_W-1:0]   c2 [N_AX];
    logic [S2_W-1:0]          c2_s;
    t_uctl                    u2_ctl;
    logic signed [UNIT_W-1:0] u2 [N_AX];
    logic [S2_W-1:0]          u2_s;
    t_uctl                    u3_ctl;
    logic signed [UNIT_W-1:0] u3 [N_Q];
    logic [0:0]               u3_s;

    logic                     r_t1v, r_t2v;
    logic signed [Q_W-1:0]    r_cx [N_AX];
    logic signed [Q_W-1:0]    r_y [N_AX];
    logic signed [Q_W-1:0]    r_z [N_AX];
    logic                     r_zneg, r_ca, r_cb, r_dg1, r_dg2;
    logic signed [Q_W-1:0]    r_q [N_Q];
    logic signed [Q_W-1:0]    n_q [N_Q];

    assign busy = 1'b0;
    assign xr[0] = i_xaxis_x;
    assign xr[1] = i_xaxis_y;
    assign xr[2] = i_xaxis_z;
    assign yr[0] = i_yaxis_x;
    assign yr[1] = i_yaxis_y;
    assign yr[2] = i_yaxis_z;

    taq_cross #(.AW(IN_W), .BW(IN_W), .SW(XS_W)) u_cross1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(start && !busy),
        .i_a(xr), .i_b(yr), .i_side({xr[2], xr[1], xr[0]}),
        .o_valid(c1_v), .o_c(c1), .o_side(c1_s)
    );

    taq_unitize #(.N(N_AX), .WI(C1_W), .SW(XS_W)) u_norm_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(c1_v), .i_v(c1), .i_side(c1_s),
        .o_ctl(u1_ctl), .o_u(u1), .o_side(u1_s)
    );

    for (genvar j = 0; j < N_AX; j++) begin : g_x1
        assign u1_x[j] = $signed(u1_s[j*IN_W +: IN_W]);
    end

    taq_cross #(.AW(UNIT_W), .BW(IN_W), .SW(S2_W)) u_cross2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(u1_ctl.valid),
        .i_a(u1), .i_b(u1_x), .i_side({u1_ctl.zero, u1[2], u1[1], u1[0], u1_s}),
        .o_valid(c2_v), .o_c(c2), .o_side(c2_s)
    );

    taq_unitize #(.N(N_AX), .WI(C2_W), .SW(S2_W)) u_norm_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(c2_v), .i_v(c2), .i_side(c2_s),
        .o_ctl(u2_ctl), .o_u(u2), .o_side(u2_s)
    );

    // trace stage 1: operands in Q30 and branch decisions
    always_ff @(posedge i_clk) begin
        logic signed [Q_W-1:0] cx0, y1;
        cx0 = Q_W'($signed(u2_s[0 +: IN_W])) <<< CX_SHIFT;
        y1  = Q_W'(u2[1]);
        for (int j = 0; j < N_AX; j++) begin
            r_cx[j] <= Q_W'($signed(u2_s[j*IN_W +: IN_W])) <<< CX_SHIFT;
            r_y[j]  <= Q_W'(u2[j]);
            r_z[j]  <= Q_W'($signed(u2_s[XS_W + j*UNIT_W +: UNIT_W]));
        end
        r_zneg <= u2_s[XS_W + 3*UNIT_W - 1];
        r_ca   <= cx0 > y1;
        r_cb   <= cx0 < -y1;
        r_dg1  <= u2_s[S2_W-1] | u2_ctl.zero;
    end

    always_comb begin
        if (r_zneg) begin
            if (r_ca) begin
                n_q[0] = r_y[2] - r_z[1];
                n_q[1] = ONE_Q30 + r_cx[0] - r_y[1] - r_z[2];
                n_q[2] = r_cx[1] + r_y[0];
                n_q[3] = r_z[0] + r_cx[2];
            end else begin
                n_q[0] = r_z[0] - r_cx[2];
                n_q[1] = r_cx[1] + r_y[0];
                n_q[2] = ONE_Q30 - r_cx[0] + r_y[1] - r_z[2];
                n_q[3] = r_y[2] + r_z[1];
            end
        end else begin
            if (r_cb) begin
                n_q[0] = r_cx[1] - r_y[0];
                n_q[1] = r_z[0] + r_cx[2];
                n_q[2] = r_y[2] + r_z[1];
                n_q[3] = ONE_Q30 - r_cx[0] - r_y[1] + r_z[2];
            end else begin
                n_q[0] = ONE_Q30 + r_cx[0] + r_y[1] + r_z[2];
                n_q[1] = r_y[2] - r_z[1];
                n_q[2] = r_z[0] - r_cx[2];
                n_q[3] = r_cx[1] - r_y[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1v <= 1'b0;
            r_t2v <= 1'b0;
        end else begin
            r_t1v <= u2_ctl.valid;
            r_t2v <= r_t1v;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < N_Q; j++) r_q[j] <= n_q[j];
        r_dg2 <= r_dg1;
    end

    taq_unitize #(.N(N_Q), .WI(Q_W), .SW(1)) u_norm_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_t2v), .i_v(r_q), .i_side(r_dg2),
        .o_ctl(u3_ctl), .o_u(u3), .o_side(u3_s)
    );

    function automatic logic signed [OUT_W-1:0] to_q14(input logic signed [UNIT_W-1:0] q);
        logic [UNIT_W-1:0] m;
        logic [OUT_W-1:0]  r;
        m = q[UNIT_W-1] ? UNIT_W'(-q) : UNIT_W'(q);
        r = OUT_W'((m + RND_HALF) >> (UNIT_W - OUT_W));
        return q[UNIT_W-1] ? $signed(-r) : $signed(r);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_done <= 1'b0;
        else          o_done <= u3_ctl.valid;
    end

    always_ff @(posedge i_clk) begin
        if (u3_s[0] || u3_ctl.zero) begin
            o_quat_w     <= Q14_ONE;
            o_quat_x     <= '0;
            o_quat_y     <= '0;
            o_quat_z     <= '0;
            o_degenerate <= 1'b1;
        end else begin
            o_quat_w     <= to_q14(u3[0]);
            o_quat_x     <= to_q14(u3[1]);
            o_quat_y     <= to_q14(u3[2]);
            o_quat_z     <= to_q14(u3[3]);
            o_degenerate <= 1'b0;
        end
    end

`ifndef SYNTHESIS
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_quat_w <= Q14_ONE && o_quat_w >= -Q14_ONE &&
                    o_quat_x <= Q14_ONE && o_quat_x >= -Q14_ONE &&
                    o_quat_y <= Q14_ONE && o_quat_y >= -Q14_ONE &&
                    o_quat_z <= Q14_ONE && o_quat_z >= -Q14_ONE))
        else $error("quaternion component out of range");

    a_ident: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_degenerate) |-> (o_quat_w == Q14_ONE && o_quat_x == '0 &&
                                      o_quat_y == '0 && o_quat_z == '0))
        else $error("degenerate item without identity");

    a_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_degenerate) |->
            (o_quat_w >= 16'sd8000 || o_quat_w <= -16'sd8000 ||
             o_quat_x >= 16'sd8000 || o_quat_x <= -16'sd8000 ||
             o_quat_y >= 16'sd8000 || o_quat_y <= -16'sd8000 ||
             o_quat_z >= 16'sd8000 || o_quat_z <= -16'sd8000))
        else $error("normalized quaternion too short");
`endif

endmodule
